>>> hdl/crn_pkg.sv
// Package for the per-channel RMS normalizer: request codes, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package crn_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_ACCUM    = 2'd1,
    REQ_FINALIZE = 2'd2,
    REQ_NORM     = 2'd3
  } req_e;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SAT = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  localparam logic [23:0] SCALE_ONE = 24'd256;
  localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;

  localparam logic [0:0] REG_NUM_CH  = 1'b0;
  localparam logic [0:0] REG_SAMPLES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_NRM_RD,
    ST_NRM_DIV,
    ST_FIN_RD,
    ST_FIN_LD,
    ST_FIN_DIV,
    ST_FIN_ROOT,
    ST_FIN_SQRT,
    ST_FIN_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic acc_rd;
    logic acc_wr;
    logic nrm_rd;
    logic nrm_start;
    logic fin_rd;
    logic div_start;
    logic sqrt_start;
    logic fin_wr;
    logic idx_rst;
    logic idx_inc;
    logic capture;
    logic out_load;
  } crn_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic fin_empty;
    logic bad_ch;
    logic busy_done;
  } crn_stat_t;

endpackage
`default_nettype wire

>>> hdl/channel_rms_normalizer_top.sv
// Top level of the per-channel RMS normalizer: APB registers, output
// register and the controller/datapath pair. Depends on crn_pkg.
//
// Channel   Signals                           Role
// in        in_valid_i/in_ready_o + fields    one request item
// out       out_valid_o/out_ready_i + fields  one result item per request
// cfg       APB psel..prdata                  num_channels, sample_count
//
// Between acceptance and the load of the output register, accumulate reads and
// writes one sum, normalize runs the shared divider (one quotient bit per cycle),
// clear zeroes every sum (one sum per cycle), and finalize walks each usable channel
// (read, divide start, 80 divide steps, root start, 32 root steps, write).
// One item is in work at a time; the next is taken once the result moves to
// the output register. Reset clears control state and marks all sums zero
// and all scales 1.0.
`default_nettype none
module channel_rms_normalizer_top import crn_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  channel_i,
  input  logic signed [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] normalized_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]  num_ch_q;
  logic [31:0] samples_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q  <= 7'd64;
      samples_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_NUM_CH:  num_ch_q  <= pwdata[6:0];
        REG_SAMPLES: samples_q <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_CH:  prdata = {25'd0, num_ch_q};
      REG_SAMPLES: prdata = samples_q;
      default:     prdata = '0;
    endcase
  end

  crn_cmd_t  cmd;
  crn_stat_t st;
  logic      idle;
  logic      out_free;
  logic [31:0] dp_norm;
  logic [1:0]  dp_stat;

  assign in_ready_o = idle;
  assign out_free   = !out_valid_o || out_ready_i;

  crn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_go_i    (in_valid_i && idle),
    .req_i      (req_e'(req_type_i)),
    .out_free_i (out_free),
    .st_i       (st),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  crn_dpath #(
    .MaxChannels (MAX_CHANNELS),
    .SampleBits  (SAMPLE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (req_type_i),
    .channel_i      (channel_i),
    .sample_i       (SAMPLE_BITS'(sample_i)),
    .num_channels_i (num_ch_q),
    .sample_count_i (samples_q),
    .st_o           (st),
    .normalized_o   (dp_norm),
    .status_o       (dp_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      normalized_o <= dp_norm;
      status_o     <= dp_stat;
    end
  end

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && !out_ready_i))
    else $error("Result loaded over an untaken item.");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_ready_o)
    else $error("Item accepted while another is in work.");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("Unknown status code.");

endmodule
`default_nettype wire

>>> hdl/crn_ctrl.sv
// Controller state machine of the RMS normalizer.
// Depends on crn_pkg; drives the datapath by command struct.
`default_nettype none
module crn_ctrl import crn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_go_i,
  input  req_e      req_i,
  input  logic      out_free_i,
  input  crn_stat_t st_i,
  output crn_cmd_t  cmd_o,
  output logic      idle_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_go_i) begin
          unique case (req_i)
            REQ_CLEAR:    state_d = ST_CLEAR;
            REQ_ACCUM:    state_d = ST_ACC_RD;
            REQ_FINALIZE: state_d = ST_FIN_RD;
            REQ_NORM:     state_d = ST_NRM_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:    if (st_i.idx_last) state_d = ST_DONE;
      ST_ACC_RD:   state_d = st_i.bad_ch ? ST_DONE : ST_ACC_WR;
      ST_ACC_WR:   state_d = ST_DONE;
      ST_NRM_RD:   state_d = st_i.bad_ch ? ST_DONE : ST_NRM_DIV;
      ST_NRM_DIV:  if (st_i.busy_done) state_d = ST_DONE;
      ST_FIN_RD:   state_d = st_i.fin_empty ? ST_DONE : ST_FIN_LD;
      ST_FIN_LD:   state_d = ST_FIN_DIV;
      ST_FIN_DIV:  if (st_i.busy_done) state_d = ST_FIN_ROOT;
      ST_FIN_ROOT: state_d = ST_FIN_SQRT;
      ST_FIN_SQRT: if (st_i.busy_done) state_d = ST_FIN_WR;
      ST_FIN_WR:   state_d = st_i.idx_last ? ST_DONE : ST_FIN_RD;
      ST_DONE:     if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    idle_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o        = 1'b1;
        cmd_o.capture = in_go_i;
        cmd_o.idx_rst = in_go_i;
      end
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      ST_ACC_RD:   cmd_o.acc_rd = 1'b1;
      ST_ACC_WR:   cmd_o.acc_wr = 1'b1;
      ST_NRM_RD: begin
        cmd_o.nrm_rd    = 1'b1;
        cmd_o.nrm_start = !st_i.bad_ch;
      end
      ST_NRM_DIV:  ;
      ST_FIN_RD:   cmd_o.fin_rd = 1'b1;
      ST_FIN_LD:   cmd_o.div_start = 1'b1;
      ST_FIN_DIV:  ;
      ST_FIN_ROOT: cmd_o.sqrt_start = 1'b1;
      ST_FIN_SQRT: ;
      ST_FIN_WR: begin
        cmd_o.fin_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      ST_DONE:     cmd_o.out_load = out_free_i;
      default:     ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/crn_dpath.sv
// Datapath of the RMS normalizer: sum and scale memories, a shared
// one-bit-per-cycle divider and square-root unit. Depends on crn_pkg.
`default_nettype none
module crn_dpath import crn_pkg::*; #(
  parameter int MaxChannels = 64,
  parameter int SampleBits  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crn_cmd_t              cmd_i,
  input  logic [1:0]            req_i,
  input  logic [5:0]            channel_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic [6:0]            num_channels_i,
  input  logic [31:0]           sample_count_i,
  output crn_stat_t             st_o,
  output logic [31:0]           normalized_o,
  output logic [1:0]            status_o
);

  localparam int IdxW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int CntW  = $clog2(MaxChannels + 1);
  localparam int MagW  = SampleBits;
  localparam int NumW  = MagW + 20;
  localparam int ChanW = 7;

  logic [63:0] sum_mem [MaxChannels];
  logic [23:0] scale_mem [MaxChannels];
  logic [MaxChannels-1:0] scale_vld_q;

  logic [63:0] sum_rd_q;
  logic [23:0] scale_rd_q;
  logic        scale_rd_vld_q;
  logic [CntW-1:0] idx_q;
  logic [1:0] req_q;
  logic [5:0] ch_q;
  logic neg_q;
  logic [MagW-1:0] mag_q;
  logic [1:0] stat_q;
  logic [31:0] res_q;

  logic [CntW-1:0] usable;
  logic [IdxW-1:0] acc_addr;
  logic [IdxW-1:0] fin_addr;
  logic [IdxW-1:0] cap_addr;
  logic ch_ok;
  logic [MagW-1:0] mag_in;

  assign usable = ({25'd0, num_channels_i} < MaxChannels) ?
                  CntW'(num_channels_i) : CntW'(MaxChannels);
  assign ch_ok    = ({1'b0, ch_q} < ChanW'(usable)) && (32'(ch_q) < MaxChannels);
  assign acc_addr = IdxW'(ch_q);
  assign fin_addr = idx_q[IdxW-1:0];
  assign cap_addr = IdxW'(channel_i);
  assign mag_in   = sample_i[SampleBits-1] ? (~sample_i + 1'b1) : sample_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      ch_q  <= channel_i;
      neg_q <= sample_i[SampleBits-1];
      mag_q <= mag_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_rst) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Sum memory; clear sweeps every entry one per cycle.
  logic [2*MagW-1:0] sq_q;
  logic [64:0] acc_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      sum_mem[fin_addr] <= '0;
    end else if (cmd_i.acc_wr) begin
      sum_mem[acc_addr] <= acc_sum[64] ? '1 : acc_sum[63:0];
    end
    if (cmd_i.acc_rd) begin
      sum_rd_q <= sum_mem[acc_addr];
    end else if (cmd_i.fin_rd) begin
      sum_rd_q <= sum_mem[fin_addr];
    end
    if (cmd_i.capture) begin
      sq_q <= mag_in * mag_in;
    end
  end

  // Sum memory holds no valid bits, so reset zeroing is emulated by a
  // written-since-reset flag per entry.
  logic [MaxChannels-1:0] sum_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= '0;
    end else if (cmd_i.clr_wr) begin
      sum_vld_q[fin_addr] <= 1'b1;
    end else if (cmd_i.acc_wr) begin
      sum_vld_q[acc_addr] <= 1'b1;
    end
  end
  logic sum_rd_vld_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_rd) begin
      sum_rd_vld_q <= sum_vld_q[acc_addr];
    end else if (cmd_i.fin_rd) begin
      sum_rd_vld_q <= sum_vld_q[fin_addr];
    end
  end
  logic [63:0] sum_eff;
  assign sum_eff = sum_rd_vld_q ? sum_rd_q : '0;
  assign acc_sum = {1'b0, sum_eff} + 65'(sq_q);

  // Shared iterative unit: restoring division, then restoring square root.
  logic        busy_q;
  logic        is_sqrt_q;
  logic [6:0]  cnt_q;
  logic [79:0] dvd_q;
  logic [64:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] dsr_q;
  logic        big_q;
  logic [64:0] trial;
  logic [31:0] divisor;
  logic [65:0] sq_rem;
  logic [65:0] sq_try;
  logic [65:0] sq_next;

  assign divisor = (sample_count_i > 32'd1) ? sample_count_i - 32'd1 : 32'd1;
  assign trial   = {rem_q[63:0], dvd_q[79]};
  assign sq_next = {rem_q[63:0], dvd_q[79:78]};
  assign sq_try  = {quo_q, 2'b01};
  assign sq_rem  = sq_next - sq_try;

  logic nrm_go;
  assign nrm_go = cmd_i.nrm_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start || nrm_go) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.div_start ? 7'd80 : 7'(NumW);
    end else if (cmd_i.sqrt_start) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd32;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != 7'd1);
    end
  end

  logic [23:0] nrm_sc;
  assign nrm_sc = scale_rd_vld_q ? scale_rd_q : SCALE_ONE;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      is_sqrt_q <= 1'b0;
      dvd_q     <= {sum_eff, 16'd0};
      rem_q     <= '0;
      quo_q     <= '0;
      dsr_q     <= divisor;
      big_q     <= 1'b0;
    end else if (nrm_go) begin
      is_sqrt_q <= 1'b0;
      dvd_q     <= {mag_q, 20'd0, {(80-NumW){1'b0}}};
      rem_q     <= '0;
      quo_q     <= '0;
      dsr_q     <= 32'(nrm_sc == 24'd0 ? SCALE_ONE : nrm_sc);
      big_q     <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      is_sqrt_q <= 1'b1;
      dvd_q     <= {quo_q, 16'd0};
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (busy_q) begin
      if (!is_sqrt_q) begin
        dvd_q <= {dvd_q[78:0], 1'b0};
        if (trial >= 65'(dsr_q)) begin
          rem_q <= trial - 65'(dsr_q);
          if (req_q == REQ_FINALIZE && cnt_q > 7'd48) begin
            big_q <= 1'b1;
          end else begin
            quo_q <= {quo_q[62:0], 1'b1};
          end
        end else begin
          rem_q <= trial;
          if (!(req_q == REQ_FINALIZE && cnt_q > 7'd48)) begin
            quo_q <= {quo_q[62:0], 1'b0};
          end
        end
      end else begin
        dvd_q <= {dvd_q[77:0], 2'b00};
        if (!sq_rem[65]) begin
          rem_q <= sq_rem[64:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= sq_next[64:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
    end
  end

  // Scale memory with per-entry valid bits (reset value 1.0).
  logic [23:0] new_scale;
  logic        scale_sat;
  always_comb begin
    scale_sat = big_q || (quo_q[63:24] != '0);
    new_scale = scale_sat ? SCALE_MAX : quo_q[23:0];
    if (new_scale == 24'd0) begin
      new_scale = SCALE_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_wr) begin
      scale_mem[fin_addr] <= new_scale;
    end
    if (cmd_i.capture) begin
      scale_rd_q <= scale_mem[cap_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_vld_q <= '0;
    end else if (cmd_i.fin_wr) begin
      scale_vld_q[fin_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      scale_rd_vld_q <= scale_vld_q[cap_addr];
    end
  end

  // Result and status.
  logic [63:0] qm;
  assign qm = quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      stat_q <= STAT_OK;
      res_q  <= '0;
    end else if (cmd_i.acc_rd && !ch_ok) begin
      stat_q <= STAT_BAD;
    end else if (cmd_i.nrm_rd && !ch_ok) begin
      stat_q <= STAT_BAD;
    end else if (cmd_i.acc_wr && acc_sum[64]) begin
      stat_q <= STAT_SAT;
    end else if (cmd_i.fin_wr && scale_sat) begin
      stat_q <= STAT_SAT;
    end else if (req_q == REQ_NORM && busy_q && cnt_q == 7'd1) begin
      res_q <= '0;
    end else if (req_q == REQ_NORM && stat_q == STAT_OK && !busy_q && cmd_i.out_load) begin
      if (!neg_q) begin
        if (qm > 64'h7FFFFFFF) begin
          res_q  <= 32'h7FFFFFFF;
          stat_q <= STAT_SAT;
        end else begin
          res_q <= qm[31:0];
        end
      end else begin
        if (qm > 64'h80000000) begin
          res_q  <= 32'h80000000;
          stat_q <= STAT_SAT;
        end else begin
          res_q <= 32'(~qm[31:0] + 32'd1);
        end
      end
    end
  end

  // Final value is formed combinationally at output load time.
  always_comb begin
    normalized_o = res_q;
    status_o     = stat_q;
    if (req_q == REQ_NORM && stat_q == STAT_OK) begin
      if (!neg_q) begin
        normalized_o = (qm > 64'h7FFFFFFF) ? 32'h7FFFFFFF : qm[31:0];
        status_o     = (qm > 64'h7FFFFFFF) ? STAT_SAT : STAT_OK;
      end else begin
        normalized_o = (qm > 64'h80000000) ? 32'h80000000 : 32'(~qm[31:0] + 32'd1);
        status_o     = (qm > 64'h80000000) ? STAT_SAT : STAT_OK;
      end
    end
  end

  assign st_o.idx_last  = (req_q == REQ_CLEAR) ? (idx_q == CntW'(MaxChannels - 1)) :
                          (idx_q + 1'b1 >= usable);
  assign st_o.fin_empty = (usable == '0);
  assign st_o.bad_ch    = !ch_ok;
  assign st_o.busy_done = busy_q && (cnt_q == 7'd1);

endmodule
`default_nettype wire
